### rtl/stfl_pkg.sv
// Shared types and codes for the slot table with embedded free list.
// No dependencies; imported by the top level.
`default_nettype none

package stfl_pkg;

  // Request operation codes
  typedef enum logic {
    OP_ADD = 1'b0,
    OP_DEL = 1'b1
  } op_t;

  // Response status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_RANGE     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_REJECT    = 3'd4
  } status_t;

endpackage : stfl_pkg

`default_nettype wire

### rtl/stfl_mem.sv
// Slot memory: one write port and one read port, read data registered.
// No package dependencies; instantiated by slot_table_free_list_allocator.
`default_nettype none

module stfl_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 42,
  parameter int AW    = 8
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered; data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : stfl_mem

`default_nettype wire

### rtl/slot_table_free_list_allocator.sv
// Slot table allocator top level: request decode, free-list control, output register.
// Depends on stfl_pkg and stfl_mem.
`default_nettype none

// Handle table of SLOTS entries. An add pops the LIFO free list or takes the
// next never-used slot and answers with the slot index; a delete frees a slot
// named by index (checked against the object when it is nonzero) or found by
// searching the live slots for the object, lowest index first. Every request
// gets exactly one response. Object, live bit and free link of a slot share
// one word of a single-read, single-write memory. An add into a never-used
// slot writes it with no memory read; an add that reuses a freed slot and
// an indexed delete do one memory read before the write-back, and a delete
// by search reads one entry per cycle through the one read port. One
// request is in work at a time; a new one is taken once the previous
// response is in the output register. The high-water count bounds every
// read, so the memory needs no clearing pass after reset.
module slot_table_free_list_allocator
  import stfl_pkg::*;
#(
  parameter int SLOTS       = 256,
  parameter int OBJECT_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_operation,
  input  wire logic [31:0] in_object_value,
  input  wire logic [7:0]  in_slot_index,
  input  wire logic        in_index_given,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [7:0]       out_result_index
);

  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int CMP_W  = (CNT_W > 8) ? CNT_W : 8;
  localparam int OW     = OBJECT_BITS;
  localparam int WORD_W = OW + IDX_W + 2;
  // word layout: {live, link_valid, link_next, object}
  localparam int LINK_LSB = OW;
  localparam int LV_BIT   = OW + IDX_W;
  localparam int LIVE_BIT = OW + IDX_W + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_OUT
  } state_t;

  state_t            state_r;
  op_t               req_op_r;
  logic [OW-1:0]     req_obj_r;
  logic [IDX_W-1:0]  req_idx_r;
  logic [CNT_W-1:0]  used_count_r;
  logic [IDX_W-1:0]  free_head_r;
  logic              head_valid_r;
  logic [CNT_W-1:0]  scan_cnt_r;
  logic              chk_valid_r;
  logic [IDX_W-1:0]  chk_addr_r;
  status_t           res_status_r;
  logic [IDX_W-1:0]  res_index_r;
  logic              out_valid_r;
  status_t           out_status_r;
  logic [7:0]        out_index_r;

  logic              accept;
  op_t               in_op;
  logic [OW-1:0]     obj_in;
  logic [CMP_W-1:0]  sidx_ext;
  logic [IDX_W-1:0]  sidx;
  logic              sidx_ok;
  logic              slot_left;
  logic              out_load;

  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic              mem_re;
  logic [IDX_W-1:0]  mem_raddr;
  logic [WORD_W-1:0] rd_data;

  logic [OW-1:0]     rd_obj;
  logic [IDX_W-1:0]  rd_link;
  logic              rd_lv;
  logic              rd_live;
  logic              obj_hit;
  logic              idx_ok;
  logic              scan_hit;
  logic [WORD_W-1:0] free_word;

  // Request decode
  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign in_op     = op_t'(in_operation);
  assign obj_in    = OW'(in_object_value);
  assign sidx_ext  = CMP_W'(in_slot_index);
  assign sidx      = sidx_ext[IDX_W-1:0];
  assign sidx_ok   = sidx_ext < CMP_W'(used_count_r);
  assign slot_left = used_count_r < CNT_W'(SLOTS);

  // Response moves into the output register when it is empty or draining
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_ready);

  // Fields of the word read back
  assign rd_obj   = rd_data[OW-1:0];
  assign rd_link  = rd_data[LINK_LSB +: IDX_W];
  assign rd_lv    = rd_data[LV_BIT];
  assign rd_live  = rd_data[LIVE_BIT];
  assign obj_hit  = rd_live && (rd_obj == req_obj_r);
  assign idx_ok   = rd_live && ((req_obj_r == '0) || (rd_obj == req_obj_r));
  assign scan_hit = chk_valid_r && obj_hit;

  // A freed slot carries the old head as its link
  assign free_word = {1'b0, head_valid_r, free_head_r, req_obj_r};

  // Memory read side
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = free_head_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_op == OP_ADD && head_valid_r) begin
          mem_re    = 1'b1;
          mem_raddr = free_head_r;
        end else if (accept && in_op == OP_DEL && in_index_given && sidx_ok) begin
          mem_re    = 1'b1;
          mem_raddr = sidx;
        end
      end
      S_SCAN: begin
        if (!scan_hit && scan_cnt_r != used_count_r) begin
          mem_re    = 1'b1;
          mem_raddr = scan_cnt_r[IDX_W-1:0];
        end
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  // Memory write side: a never-used slot on an add, or write-back of the modified slot
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = req_idx_r;
    mem_wdata = free_word;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_op == OP_ADD && !head_valid_r && slot_left) begin
          mem_we    = 1'b1;
          mem_waddr = used_count_r[IDX_W-1:0];
          mem_wdata = {1'b1, 1'b0, {IDX_W{1'b0}}, obj_in};
        end
      end
      S_READ: begin
        if (req_op_r == OP_ADD) begin
          mem_we    = 1'b1;
          mem_wdata = {1'b1, 1'b0, {IDX_W{1'b0}}, req_obj_r};
        end else if (idx_ok) begin
          mem_we = 1'b1;
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          mem_we    = 1'b1;
          mem_waddr = chk_addr_r;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  stfl_mem #(
    .DEPTH (SLOTS),
    .WIDTH (WORD_W),
    .AW    (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  // Control state machine and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      used_count_r <= '0;
      head_valid_r <= 1'b0;
      chk_valid_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            req_op_r  <= in_op;
            req_obj_r <= obj_in;
            if (in_op == OP_ADD) begin
              if (head_valid_r) begin
                req_idx_r <= free_head_r;
                state_r   <= S_READ;
              end else if (slot_left) begin
                used_count_r <= used_count_r + CNT_W'(1);
                res_status_r <= ST_OK;
                res_index_r  <= used_count_r[IDX_W-1:0];
                state_r      <= S_OUT;
              end else begin
                res_status_r <= ST_FULL;
                res_index_r  <= '0;
                state_r      <= S_OUT;
              end
            end else if (in_index_given) begin
              if (sidx_ok) begin
                req_idx_r <= sidx;
                state_r   <= S_READ;
              end else begin
                res_status_r <= ST_RANGE;
                res_index_r  <= '0;
                state_r      <= S_OUT;
              end
            end else begin
              scan_cnt_r  <= '0;
              chk_valid_r <= 1'b0;
              state_r     <= S_SCAN;
            end
          end
        end
        S_READ: begin
          if (req_op_r == OP_ADD) begin
            // pop: the slot's link becomes the new head
            head_valid_r <= rd_lv;
            free_head_r  <= rd_link;
            res_status_r <= ST_OK;
            res_index_r  <= req_idx_r;
          end else if (idx_ok) begin
            free_head_r  <= req_idx_r;
            head_valid_r <= 1'b1;
            res_status_r <= ST_OK;
            res_index_r  <= req_idx_r;
          end else begin
            res_status_r <= ST_REJECT;
            res_index_r  <= '0;
          end
          state_r <= S_OUT;
        end
        S_SCAN: begin
          // read issue and compare overlap: the entry read last is compared while the next read issues
          if (scan_hit) begin
            free_head_r  <= chk_addr_r;
            head_valid_r <= 1'b1;
            res_status_r <= ST_OK;
            res_index_r  <= chk_addr_r;
            chk_valid_r  <= 1'b0;
            state_r      <= S_OUT;
          end else if (scan_cnt_r == used_count_r) begin
            res_status_r <= ST_NOT_FOUND;
            res_index_r  <= '0;
            chk_valid_r  <= 1'b0;
            state_r      <= S_OUT;
          end else begin
            chk_valid_r <= 1'b1;
            chk_addr_r  <= scan_cnt_r[IDX_W-1:0];
            scan_cnt_r  <= scan_cnt_r + CNT_W'(1);
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_status_r <= res_status_r;
            out_index_r  <= 8'(res_index_r);
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_index = out_index_r;

endmodule : slot_table_free_list_allocator

`default_nettype wire

### test/testbench.sv
// Testbench for slot_table_free_list_allocator: directed and random add/delete requests,
// checked against an in-bench model of the slot table and its free list.
// Depends on stfl_pkg and the allocator RTL.

module testbench;
  import stfl_pkg::*;

  localparam int SLOTS = 256;
  localparam int STALL_LIMIT = 3000;

  typedef struct {
    op_t         op;
    logic [31:0] obj;
    logic [7:0]  slot;
    logic        by_index;
  } request_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] slot;
  } response_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_operation = 1'b0;
  logic [31:0] in_object_value = '0;
  logic [7:0]  in_slot_index = '0;
  logic        in_index_given = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [7:0]  out_result_index;

  slot_table_free_list_allocator #(
    .SLOTS      (SLOTS),
    .OBJECT_BITS(32)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_object_value (in_object_value),
    .in_slot_index   (in_slot_index),
    .in_index_given  (in_index_given),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_result_index(out_result_index)
  );

  // Clock: period 12
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Table model: objects, live bits, free-list links, high-water count
  logic [31:0] table_obj [SLOTS];
  bit          slot_live [SLOTS];
  int          chain_next [SLOTS];
  bit          chain_valid [SLOTS];
  int          used_count = 0;
  int          free_head = 0;
  bit          head_valid = 1'b0;

  response_t   pending_responses[$];
  int          mismatch_count = 0;
  int          add_count = 0;
  int          del_count = 0;
  int          status_tally[5];

  // Idle control shared by the test tasks and the two channel drivers
  bit          send_idle_on = 1'b1;
  bit          recv_idle_on = 1'b1;
  int          hold_cycles = 0;

  // Apply one request to the table model and return the response it gives
  function automatic response_t apply_table_request(request_t req);
    response_t rsp;
    int        idx;
    int        i;
    bit        found;
    rsp.status = ST_OK;
    rsp.slot   = '0;
    idx        = 0;
    found      = 1'b0;
    if (req.op == OP_ADD) begin
      if (head_valid) begin
        idx        = free_head;
        head_valid = chain_valid[idx];
        free_head  = chain_next[idx];
      end else if (used_count < SLOTS) begin
        idx = used_count;
        used_count++;
      end else begin
        rsp.status = ST_FULL;
        return rsp;
      end
      table_obj[idx] = req.obj;
      slot_live[idx] = 1'b1;
      rsp.slot       = 8'(idx);
      return rsp;
    end
    if (req.by_index) begin
      if (int'(req.slot) >= used_count) begin
        rsp.status = ST_RANGE;
        return rsp;
      end
      idx = req.slot;
      if (!slot_live[idx] || (req.obj != '0 && table_obj[idx] != req.obj)) begin
        rsp.status = ST_REJECT;
        return rsp;
      end
    end else begin
      // lowest live slot holding the object wins
      for (i = 0; i < used_count; i++) begin
        if (!found && slot_live[i] && table_obj[i] == req.obj) begin
          idx   = i;
          found = 1'b1;
        end
      end
      if (!found) begin
        rsp.status = ST_NOT_FOUND;
        return rsp;
      end
    end
    // push freed slot on the LIFO free list
    slot_live[idx]   = 1'b0;
    chain_next[idx]  = free_head;
    chain_valid[idx] = head_valid;
    free_head        = idx;
    head_valid       = 1'b1;
    rsp.slot         = 8'(idx);
    return rsp;
  endfunction

  function automatic bit table_full();
    return !head_valid && used_count == SLOTS;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_live_slot();
    int candidates[$];
    int i;
    for (i = 0; i < used_count; i++)
      if (slot_live[i]) candidates = {candidates, i};
    if (candidates.size() == 0) return -1;
    return candidates[$urandom_range(0, candidates.size() - 1)];
  endfunction

  // Objects: some zero, a small pool of repeats, the rest fully random
  function automatic logic [31:0] rand_object();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 35) return 32'hC0DE_0000 | 32'($urandom_range(1, 6));
    return $urandom;
  endfunction

  // Random request: an add by add_weight, else mostly well-formed deletes of live slots, some noise
  function automatic request_t random_request(int add_weight);
    request_t    req;
    int          slot;
    int unsigned r;
    req.op       = OP_ADD;
    req.obj      = rand_object();
    req.slot     = 8'($urandom_range(0, 255));
    req.by_index = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < add_weight) return req;
    req.op = OP_DEL;
    slot   = pick_live_slot();
    r      = (slot < 0) ? $urandom_range(80, 99) : $urandom_range(0, 99);
    if (r < 40) begin
      req.by_index = 1'b1;
      req.slot     = 8'(slot);
      req.obj      = $urandom_range(0, 1) ? table_obj[slot] : '0;
    end else if (r < 80) begin
      req.by_index = 1'b0;
      req.obj      = table_obj[slot];
    end else if (r < 87 || slot < 0) begin
      // random index and object: range, double-free or mismatch mostly
      req.by_index = r < 94;
    end else if (r < 94) begin
      req.by_index = 1'b1;
      req.slot     = 8'(slot);
      req.obj      = table_obj[slot] ^ (32'h1 << $urandom_range(0, 31));
    end else begin
      req.by_index = 1'b0;
    end
    return req;
  endfunction

  task automatic report_mismatch(string what);
    $display("ERROR @%0t: %s", $time, what);
    mismatch_count++;
  endtask

  // Send one request; called and returns at a falling edge
  task automatic send_request(request_t req);
    response_t rsp;
    int        gap;
    gap = send_idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= req.op;
    in_object_value <= req.obj;
    in_slot_index   <= req.slot;
    in_index_given  <= req.by_index;
    do @(posedge clk); while (!in_ready);
    rsp = apply_table_request(req);
    pending_responses = {pending_responses, rsp};
    status_tally[rsp.status]++;
    if (req.op == OP_ADD) add_count++;
    else del_count++;
    @(negedge clk);
  endtask

  // Receiver: random stalls, or a long hold-off when a test asks for one
  initial begin : drive_out_ready
    int gap;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
        out_ready <= 1'b1;
      end else if (recv_idle_on) begin
        gap = pick_gap();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Response checker
  always @(posedge clk) begin : check_responses
    response_t due;
    if (rst_n && out_valid && out_ready) begin
      if (pending_responses.size() == 0) begin
        report_mismatch($sformatf("unexpected response: status %0d slot %0d",
                                  out_status, out_result_index));
      end else begin
        due = pending_responses.pop_front();
        if (out_status !== due.status)
          report_mismatch($sformatf("status %0d, expected %s", out_status,
                                    due.status.name()));
        if (out_result_index !== due.slot)
          report_mismatch($sformatf("slot %0d, expected %0d", out_result_index,
                                    due.slot));
      end
    end
  end

  // Watchdog: cycles with no handshake on either channel
  always @(posedge clk) begin : watchdog
    int quiet;
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("Timeout: no handshake for %0d cycles", quiet);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Fresh slots 0..5, object extremes, a duplicate value
  task automatic test_add_extremes();
    send_request('{OP_ADD, 32'h0000_0000, 8'hFF, 1'b1});
    send_request('{OP_ADD, 32'hFFFF_FFFF, 8'h00, 1'b0});
    send_request('{OP_ADD, 32'hAAAA_AAAA, 8'hAA, 1'b1});
    send_request('{OP_ADD, 32'h5555_5555, 8'h55, 1'b0});
    send_request('{OP_ADD, 32'h1234_5678, 8'h00, 1'b0});
    send_request('{OP_ADD, 32'h1234_5678, 8'h00, 1'b0});
  endtask

  // Range, mismatch, double free, zero search, duplicate search, not found
  task automatic test_delete_rules();
    send_request('{OP_DEL, 32'h0000_0000, 8'd7,   1'b1});
    send_request('{OP_DEL, 32'h0000_0000, 8'd255, 1'b1});
    send_request('{OP_DEL, 32'h5555_5555, 8'd2,   1'b1});
    send_request('{OP_DEL, 32'h0000_0000, 8'd2,   1'b1});
    send_request('{OP_DEL, 32'h0000_0000, 8'd2,   1'b1});
    send_request('{OP_DEL, 32'h1234_5678, 8'd0,   1'b0});
    send_request('{OP_DEL, 32'h0000_0000, 8'd0,   1'b0});
    send_request('{OP_DEL, 32'hDEAD_BEEF, 8'd0,   1'b0});
    send_request('{OP_DEL, 32'h0000_0000, 8'd0,   1'b0});
    send_request('{OP_DEL, 32'hFFFF_FFFF, 8'd1,   1'b1});
  endtask

  // Freed slots come back last-in first-out, then a never-used slot
  task automatic test_free_list_reuse();
    repeat (5) send_request('{OP_ADD, rand_object(), 8'($urandom_range(0, 255)), 1'b0});
  endtask

  // Fill to capacity, adds on a full table, free the top slot and refill
  task automatic test_full_table();
    while (!table_full())
      send_request('{OP_ADD, rand_object(), 8'($urandom_range(0, 255)), 1'b1});
    repeat (3) send_request('{OP_ADD, rand_object(), 8'h00, 1'b0});
    send_request('{OP_DEL, 32'h0000_0000, 8'd255, 1'b1});
    send_request('{OP_ADD, 32'h8000_0001, 8'h00, 1'b0});
    send_request('{OP_ADD, 32'h8000_0002, 8'h00, 1'b0});
  endtask

  // Receiver holds off while requests keep coming, so the input stalls
  task automatic test_back_pressure();
    send_idle_on = 1'b0;
    hold_cycles  = 200;
    repeat (10) send_request(random_request(50));
    send_idle_on = 1'b1;
  endtask

  // Random traffic, alternating fill- and drain-heavy stretches
  task automatic test_random_mix(int count);
    int add_weight;
    int n;
    add_weight = 70;
    for (n = 0; n < count; n++) begin
      if (n % 150 == 0) add_weight = (add_weight == 70) ? 30 : 70;
      if (n % 100 == 0) begin
        send_idle_on = ($urandom_range(0, 3) != 0);
        recv_idle_on = ($urandom_range(0, 3) != 0);
      end
      send_request(random_request(add_weight));
    end
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
  endtask

  initial begin : run_tests
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    test_add_extremes();
    test_delete_rules();
    test_free_list_reuse();
    test_full_table();
    test_back_pressure();
    test_random_mix(760);
    in_valid     <= 1'b0;
    recv_idle_on = 1'b0;
    wait (pending_responses.size() == 0);
    repeat (8) @(posedge clk);
    $display("Run covered %0d requests: %0d adds, %0d deletes (index and search).",
             add_count + del_count, add_count, del_count);
    $display("Responses ok/full/range/not-found/reject: %0d/%0d/%0d/%0d/%0d",
             status_tally[ST_OK], status_tally[ST_FULL], status_tally[ST_RANGE],
             status_tally[ST_NOT_FOUND], status_tally[ST_REJECT]);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
